// ===== rtl/core/beacon_ssid_count_table_top_assert.svh =====
`ifndef BEACON_SSID_COUNT_TABLE_TOP_ASSERT_SVH
`define BEACON_SSID_COUNT_TABLE_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BSCT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define BSCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bsct_pkg.sv =====
package bsct_pkg;

  typedef enum logic [1:0] {
    OpByte  = 2'd0,
    OpTick  = 2'd1,
    OpFlush = 2'd2,
    OpNone  = 2'd3
  } op_e;

  typedef enum logic [8:0] {
    StIdle   = 9'b000000001,
    StSrch   = 9'b000000010,
    StCmp    = 9'b000000100,
    StPost   = 9'b000001000,
    StRLoad  = 9'b000010000,
    StRStart = 9'b000100000,
    StRWait  = 9'b001000000,
    StROut   = 9'b010000000,
    StREmpty = 9'b100000000
  } state_e;

  localparam logic CfgReportInterval = 1'b0;
  localparam logic CfgSsidOffset     = 1'b1;

  localparam logic [15:0] ReportIntervalRst = 16'd10;
  localparam logic [10:0] SsidOffsetRst     = 11'd56;
  localparam logic [7:0]  BeaconType        = 8'h80;
  localparam logic [7:0]  NameEndMax        = 8'h01;
  localparam int unsigned ShareW            = 14;
  localparam int unsigned ProdW             = 46;
  localparam logic [ShareW-1:0] ShareScale  = 14'd10000;
  localparam int unsigned NameMaxW          = 256;

endpackage

// ===== rtl/core/bsct_ram.sv =====
module bsct_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/bsct_div.sv =====
module bsct_div import bsct_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [ProdW-1:0]  dividend_i,
  input  logic [31:0]       divisor_i,
  output logic              done_o,
  output logic [ShareW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(ShareW);

  logic [31:0]       rem_q, rem_d;
  logic [ShareW-1:0] low_q, low_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              run_q, run_d;
  logic              done_q, done_d;
  logic [32:0]       trial;
  logic              ge;

  always_comb begin
    trial  = {rem_q, low_q[ShareW-1]};
    ge     = trial >= {1'b0, divisor_i};
    rem_d  = rem_q;
    low_d  = low_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = dividend_i[ProdW-1:ShareW];
      low_d = dividend_i[ShareW-1:0];
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      rem_d = ge ? 32'(trial - {1'b0, divisor_i}) : trial[31:0];
      low_d = {low_q[ShareW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(ShareW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      low_q  <= '0;
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      rem_q  <= rem_d;
      low_q  <= low_d;
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = low_q;

endmodule

// ===== rtl/core/beacon_ssid_count_table_top.sv =====
// Beacon SSID frequency table.
// Input channel: op_i, data_byte_i, last_byte_i, transferred when start is high
// and busy is low. Frame bytes that do not end a frame leave busy low. A last
// byte of a beacon frame starts a linear search of the name table: each slot in
// use is read through the name RAM read port and compared, then the name is
// counted or inserted (or dropped when the table is full) and the search ends.
// A report (flush, or after a beacon once the elapsed ticks reach the
// interval) fetches and scales the count of each entry, runs the iterative
// share divider, then gives one result per 8-byte name chunk.
// An empty table gives one result.
// Results: presented under result_strobe_o; the receiver must take each
// in that cycle, there is no back-pressure.
// Configuration: cfg_valid_i/cfg_ready_o transfer, always ready; write only
// while busy is low. Reset clears counters and the frame tracker; the name
// table needs no clearing pass since only slots in use are read.
`include "beacon_ssid_count_table_top_assert.svh"

module beacon_ssid_count_table_top import bsct_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned NAME_BYTES  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        result_strobe_o,
  output logic        entry_valid_o,
  output logic [3:0]  slot_o,
  output logic [1:0]  chunk_o,
  output logic [63:0] name_chunk_o,
  output logic [5:0]  name_length_o,
  output logic [31:0] entry_count_o,
  output logic [31:0] total_count_o,
  output logic [13:0] share_hundredths_o,
  output logic [15:0] dropped_names_o,
  output logic        last_result_o
);

  localparam int unsigned IdxW  = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned UsedW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned NameW = NAME_BYTES * 8;
  localparam int unsigned NbW   = $clog2(NAME_BYTES);

  state_e            state_q, state_d;
  logic [15:0]       interval_q, interval_d;
  logic [10:0]       offset_q, offset_d;
  logic [5:0]        len_q [TABLE_DEPTH];
  logic [31:0]       cnt_q [TABLE_DEPTH];
  logic [UsedW-1:0]  used_q, used_d;
  logic [31:0]       total_q, total_d;
  logic [15:0]       elapsed_q, elapsed_d;
  logic [15:0]       pos_q, pos_d;
  logic [15:0]       rlen_q, rlen_d;
  logic              beacon_q, beacon_d;
  logic [NameW-1:0]  nb_q, nb_d;
  logic [5:0]        nb_len_q, nb_len_d;
  logic              term_q, term_d;
  logic [15:0]       drop_q, drop_d;
  logic [UsedW-1:0]  idx_q, idx_d;
  logic [1:0]        chk_q, chk_d;
  logic [ProdW-1:0]  prod_q, prod_d;
  logic [ShareW-1:0] share_q, share_d;

  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr;
  logic [NameW-1:0]  ram_rdata;
  logic              len_we, cnt_we;
  logic [31:0]       cnt_wdata;
  logic [IdxW-1:0]   wr_idx;
  logic              div_start, div_done;
  logic [ShareW-1:0] div_quot;
  logic [IdxW-1:0]   rd_idx;
  logic [NameMaxW-1:0] name_pad;
  logic              last_chunk;
  logic              last_slot;

  assign rd_idx     = idx_q[IdxW-1:0];
  assign name_pad   = NameMaxW'(ram_rdata);
  assign last_chunk = ({3'b0, chk_q, 3'b000} + 8'd8) >= {2'b0, len_q[rd_idx]};
  assign last_slot  = (idx_q + 1'b1) == used_q;

  bsct_ram #(
    .Width (NameW),
    .Depth (TABLE_DEPTH)
  ) u_name_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (nb_q),
    .raddr_i (rd_idx),
    .rdata_o (ram_rdata)
  );

  bsct_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (total_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign cfg_ready_o = 1'b1;
  assign busy        = state_q != StIdle;
  assign div_start   = state_q == StRStart;

  always_comb begin
    state_d    = state_q;
    interval_d = interval_q;
    offset_d   = offset_q;
    used_d     = used_q;
    total_d    = total_q;
    elapsed_d  = elapsed_q;
    pos_d      = pos_q;
    rlen_d     = rlen_q;
    beacon_d   = beacon_q;
    nb_d       = nb_q;
    nb_len_d   = nb_len_q;
    term_d     = term_q;
    drop_d     = drop_q;
    idx_d      = idx_q;
    chk_d      = chk_q;
    prod_d     = prod_q;
    share_d    = share_q;
    ram_we     = 1'b0;
    ram_waddr  = used_q[IdxW-1:0];
    len_we     = 1'b0;
    cnt_we     = 1'b0;
    cnt_wdata  = 32'd1;
    wr_idx     = used_q[IdxW-1:0];

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgReportInterval: interval_d = cfg_data_i;
        CfgSsidOffset:     offset_d   = cfg_data_i[10:0];
        default:           offset_d   = offset_q;
      endcase
    end

    unique case (state_q)
      StIdle: begin
        if (start) begin
          case (op_e'(op_i))
            OpByte: begin
              if (pos_q == 16'd2) begin
                rlen_d = {rlen_q[15:8], data_byte_i};
              end else if (pos_q == 16'd3) begin
                rlen_d = {data_byte_i, rlen_q[7:0]};
              end else if (pos_q >= 16'd4 && pos_q == rlen_q) begin
                beacon_d = data_byte_i == BeaconType;
              end
              if (pos_q >= {5'b0, offset_q} && !term_q) begin
                if (data_byte_i <= NameEndMax) begin
                  term_d = 1'b1;
                end else if (nb_len_q < 6'(NAME_BYTES)) begin
                  nb_d[nb_len_q[NbW-1:0]*8 +: 8] = data_byte_i;
                  nb_len_d = nb_len_q + 1'b1;
                end
              end
              if (pos_q != 16'hFFFF) begin
                pos_d = pos_q + 1'b1;
              end
              if (last_byte_i) begin
                if (beacon_d) begin
                  idx_d   = '0;
                  state_d = StSrch;
                end else begin
                  nb_d     = '0;
                  nb_len_d = '0;
                end
                pos_d    = '0;
                rlen_d   = '0;
                beacon_d = 1'b0;
                term_d   = 1'b0;
              end
            end
            OpTick: begin
              if (elapsed_q != 16'hFFFF) begin
                elapsed_d = elapsed_q + 1'b1;
              end
            end
            OpFlush: begin
              idx_d   = '0;
              chk_d   = '0;
              state_d = (used_q == '0) ? StREmpty : StRLoad;
            end
            default: state_d = StIdle;
          endcase
        end
      end
      StSrch: begin
        if (idx_q == used_q) begin
          if (used_q < UsedW'(TABLE_DEPTH)) begin
            ram_we  = 1'b1;
            len_we  = 1'b1;
            cnt_we  = 1'b1;
            used_d  = used_q + 1'b1;
            if (total_q != 32'hFFFF_FFFF) begin
              total_d = total_q + 1'b1;
            end
          end else if (drop_q != 16'hFFFF) begin
            drop_d = drop_q + 1'b1;
          end
          state_d = StPost;
        end else begin
          state_d = StCmp;
        end
      end
      StCmp: begin
        if (ram_rdata == nb_q && len_q[rd_idx] == nb_len_q) begin
          wr_idx    = rd_idx;
          cnt_we    = cnt_q[rd_idx] != 32'hFFFF_FFFF;
          cnt_wdata = cnt_q[rd_idx] + 1'b1;
          if (total_q != 32'hFFFF_FFFF) begin
            total_d = total_q + 1'b1;
          end
          state_d = StPost;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = StSrch;
        end
      end
      StPost: begin
        nb_d     = '0;
        nb_len_d = '0;
        idx_d    = '0;
        chk_d    = '0;
        if (elapsed_q >= interval_q) begin
          elapsed_d = '0;
          state_d   = (used_q == '0) ? StREmpty : StRLoad;
        end else begin
          state_d = StIdle;
        end
      end
      StRLoad: begin
        prod_d  = ProdW'(cnt_q[rd_idx]) * ProdW'(ShareScale);
        state_d = StRStart;
      end
      StRStart: begin
        state_d = StRWait;
      end
      StRWait: begin
        if (div_done) begin
          share_d = (total_q == '0) ? '0 : div_quot;
          state_d = StROut;
        end
      end
      StROut: begin
        if (last_chunk) begin
          chk_d = '0;
          if (last_slot) begin
            used_d  = '0;
            total_d = '0;
            drop_d  = '0;
            state_d = StIdle;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = StRLoad;
          end
        end else begin
          chk_d = chk_q + 1'b1;
        end
      end
      StREmpty: begin
        used_d  = '0;
        total_d = '0;
        drop_d  = '0;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      interval_q <= ReportIntervalRst;
      offset_q   <= SsidOffsetRst;
      used_q     <= '0;
      total_q    <= '0;
      elapsed_q  <= '0;
      pos_q      <= '0;
      rlen_q     <= '0;
      beacon_q   <= 1'b0;
      nb_q       <= '0;
      nb_len_q   <= '0;
      term_q     <= 1'b0;
      drop_q     <= '0;
      idx_q      <= '0;
      chk_q      <= '0;
    end else begin
      state_q    <= state_d;
      interval_q <= interval_d;
      offset_q   <= offset_d;
      used_q     <= used_d;
      total_q    <= total_d;
      elapsed_q  <= elapsed_d;
      pos_q      <= pos_d;
      rlen_q     <= rlen_d;
      beacon_q   <= beacon_d;
      nb_q       <= nb_d;
      nb_len_q   <= nb_len_d;
      term_q     <= term_d;
      drop_q     <= drop_d;
      idx_q      <= idx_d;
      chk_q      <= chk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    share_q <= share_d;
    if (len_we) begin
      len_q[wr_idx] <= nb_len_q;
    end
    if (cnt_we) begin
      cnt_q[wr_idx] <= cnt_wdata;
    end
  end

  always_comb begin
    result_strobe_o    = state_q == StROut || state_q == StREmpty;
    entry_valid_o      = state_q == StROut;
    total_count_o      = total_q;
    dropped_names_o    = drop_q;
    if (state_q == StROut) begin
      slot_o             = 4'(rd_idx);
      chunk_o            = chk_q;
      name_chunk_o       = name_pad[chk_q*64 +: 64];
      name_length_o      = len_q[rd_idx];
      entry_count_o      = cnt_q[rd_idx];
      share_hundredths_o = share_q;
      last_result_o      = last_chunk && last_slot;
    end else begin
      slot_o             = '0;
      chunk_o            = '0;
      name_chunk_o       = '0;
      name_length_o      = '0;
      entry_count_o      = '0;
      share_hundredths_o = '0;
      last_result_o      = state_q == StREmpty;
    end
  end

  `BSCT_ASSERT_NOW(a_result_busy, result_strobe_o, busy, "result outside a busy period")
  `BSCT_ASSERT_NEXT(a_last_ends, result_strobe_o && last_result_o, !result_strobe_o,
                    "result after last of report")
  `BSCT_ASSERT_NEXT(a_flush_busy, start && !busy && op_i == OpFlush, busy,
                    "flush did not start a report")
  `BSCT_ASSERT_NOW(a_used_range, 1'b1, used_q <= UsedW'(TABLE_DEPTH), "table overfilled")

endmodule

// ===== sim/beacon_ssid_count_table_top_tb.sv =====
`timescale 1ns / 100ps

module beacon_ssid_count_table_top_tb;
  import bsct_pkg::*;

  typedef struct packed {
    logic        entry_valid;
    logic [3:0]  slot;
    logic [1:0]  chunk;
    logic [63:0] name_chunk;
    logic [5:0]  name_length;
    logic [31:0] entry_count;
    logic [31:0] total_count;
    logic [13:0] share;
    logic [15:0] dropped;
    logic        last_result;
  } report_line_t;

  class ssid_table_sb;
    logic [15:0] interval;
    logic [10:0] offset;
    logic [7:0]  names [16][32];
    logic [5:0]  lens [16];
    logic [31:0] counts [16];
    int          used;
    logic [31:0] total;
    logic [15:0] ticks;
    logic [15:0] pos;
    logic [15:0] rlen;
    bit          is_beacon;
    logic [7:0]  nbuf [32];
    logic [5:0]  nlen;
    bit          term;
    logic [15:0] drops;
    report_line_t pending [$];
    int          errors;

    function new();
      interval = ReportIntervalRst;
      offset = SsidOffsetRst;
      used = 0; total = 0; ticks = 0; drops = 0; errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      pos = 0; rlen = 0; is_beacon = 0; nlen = 0; term = 0;
      foreach (nbuf[i]) nbuf[i] = 8'h00;
    endfunction

    function void push_report();
      report_line_t r;
      int chunks;
      logic [63:0] share;
      if (used == 0) begin
        r = '0;
        r.total_count = total;
        r.dropped = drops;
        r.last_result = 1'b1;
        pending.push_back(r);
      end else begin
        for (int s = 0; s < used; s++) begin
          chunks = (lens[s] + 7) / 8;
          if (chunks == 0) chunks = 1;
          share = (total != 0) ? (64'(counts[s]) * 64'd10000) / 64'(total) : 64'd0;
          for (int c = 0; c < chunks; c++) begin
            r = '0;
            for (int b = 0; b < 8; b++)
              if (c * 8 + b < lens[s]) r.name_chunk[8*b +: 8] = names[s][c*8+b];
            r.entry_valid = 1'b1;
            r.slot = s[3:0];
            r.chunk = c[1:0];
            r.name_length = lens[s];
            r.entry_count = counts[s];
            r.total_count = total;
            r.share = share[13:0];
            r.dropped = drops;
            r.last_result = (s == used - 1) && (c == chunks - 1);
            pending.push_back(r);
          end
        end
      end
      used = 0; total = 0; drops = 0;
    endfunction

    function void insert_name();
      bit same;
      for (int i = 0; i < used; i++) begin
        same = (lens[i] == nlen);
        for (int k = 0; k < 32; k++) if (names[i][k] !== nbuf[k]) same = 0;
        if (same) begin
          if (counts[i] != '1) counts[i]++;
          if (total != '1) total++;
          return;
        end
      end
      if (used < 16) begin
        names[used] = nbuf;
        lens[used] = nlen;
        counts[used] = 1;
        used++;
        if (total != '1) total++;
      end else if (drops != '1) begin
        drops++;
      end
    endfunction

    function void note_item(op_e op, logic [7:0] data, logic last);
      case (op)
        OpTick: begin
          if (ticks != '1) ticks++;
        end
        OpFlush: begin
          push_report();
        end
        OpByte: begin
          if (pos == 2) rlen[7:0] = data;
          else if (pos == 3) rlen[15:8] = data;
          else if (pos >= 4 && pos == rlen) is_beacon = (data == BeaconType);
          if (pos >= offset && !term) begin
            if (data <= NameEndMax) term = 1;
            else if (nlen < 32) begin
              nbuf[nlen] = data;
              nlen++;
            end
          end
          if (pos != '1) pos++;
          if (last) begin
            if (is_beacon) begin
              insert_name();
              if (ticks >= interval) begin
                ticks = 0;
                push_report();
              end
            end
            clear_frame();
          end
        end
        default: ;
      endcase
    endfunction

    function void cmp(string field, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0h, got %0h", field, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(report_line_t got);
      report_line_t e;
      if (pending.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
        return;
      end
      e = pending.pop_front();
      cmp("entry_valid", e.entry_valid, got.entry_valid);
      cmp("slot", e.slot, got.slot);
      cmp("chunk", e.chunk, got.chunk);
      cmp("name_chunk", e.name_chunk, got.name_chunk);
      cmp("name_length", e.name_length, got.name_length);
      cmp("entry_count", e.entry_count, got.entry_count);
      cmp("total_count", e.total_count, got.total_count);
      cmp("share_hundredths", e.share, got.share);
      cmp("dropped_names", e.dropped, got.dropped);
      cmp("last_result", e.last_result, got.last_result);
    endfunction
  endclass

  localparam int WatchdogLimit = 20000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start = 0;
  logic        busy;
  logic [1:0]  op_i = OpNone;
  logic [7:0]  data_byte_i = '0;
  logic        last_byte_i = 0;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic        cfg_index_i = CfgReportInterval;
  logic [15:0] cfg_data_i = '0;
  logic        result_strobe_o;
  logic        entry_valid_o;
  logic [3:0]  slot_o;
  logic [1:0]  chunk_o;
  logic [63:0] name_chunk_o;
  logic [5:0]  name_length_o;
  logic [31:0] entry_count_o;
  logic [31:0] total_count_o;
  logic [13:0] share_hundredths_o;
  logic [15:0] dropped_names_o;
  logic        last_result_o;

  ssid_table_sb sb = new();
  int          gap_mode;
  int          quiet_cycles;
  logic [7:0]  pool [20][40];
  int          pool_len [20];

  beacon_ssid_count_table_top u_dut (.*);

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_strobe_o)
        sb.check_result({entry_valid_o, slot_o, chunk_o, name_chunk_o, name_length_o,
                         entry_count_o, total_count_o, share_hundredths_o,
                         dropped_names_o, last_result_o});
      if ((start && !busy) || result_strobe_o || (cfg_valid_i && cfg_ready_o))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic int draw_gap();
    return (gap_mode == 0) ? 0 : $urandom_range(0, 19);
  endfunction

  task automatic send_item(op_e op, logic [7:0] data, logic last);
    int gap;
    gap = draw_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1;
    op_i <= op;
    data_byte_i <= data;
    last_byte_i <= last;
    do @(posedge clk_i); while (busy);
    sb.note_item(op, data, last);
  endtask

  // hold off until every expected transfer has arrived and the block is idle
  task automatic drain();
    @(negedge clk_i);
    start <= 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    while (busy) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [15:0] val);
    drain();
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CfgReportInterval) sb.interval = val;
    else sb.offset = val[10:0];
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  // term_kind: 0 or 1 ends the name with that byte, 2 leaves it open
  task automatic send_frame(bit beacon, int rl, int nm, int term_kind, int tail, int cut);
    logic [7:0] fb [$];
    int n;
    int off;
    off = sb.offset;
    n = ((rl + 1) > (off + pool_len[nm] + 1) ? rl + 1 : off + pool_len[nm] + 1) + tail;
    if (cut > 0) n = cut;
    for (int i = 0; i < n; i++) fb.push_back($urandom_range(0, 255));
    if (n > 2) fb[2] = rl[7:0];
    if (n > 3) fb[3] = rl[15:8];
    if (rl < n) fb[rl] = beacon ? BeaconType : 8'($urandom_range(0, 127));
    for (int k = 0; k < pool_len[nm]; k++) if (off + k < n) fb[off+k] = pool[nm][k];
    if (off + pool_len[nm] < n && term_kind < 2) fb[off+pool_len[nm]] = term_kind[7:0];
    for (int i = 0; i < n; i++) send_item(OpByte, fb[i], i == n - 1);
  endtask

  task automatic random_frame();
    send_frame(1, $urandom_range(4, 12), $urandom_range(0, 19), $urandom_range(0, 2),
               $urandom_range(0, 4), 0);
  endtask

  initial begin
    int r;
    for (int p = 0; p < 20; p++) begin
      pool_len[p] = (p == 0) ? 0 : (p == 1) ? 40 : $urandom_range(1, 20);
      for (int k = 0; k < 40; k++) pool[p][k] = $urandom_range(2, 255);
    end
    pool[2][0] = 8'hFF;
    gap_mode = 0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1;

    send_item(OpFlush, 0, 0);
    send_item(OpNone, 8'hFF, 1);
    send_item(OpTick, 8'hA5, 1);
    write_cfg(CfgSsidOffset, 16'd10);
    send_frame(1, 6, 0, 0, 2, 0);
    send_frame(1, 6, 1, 2, 3, 0);
    send_frame(1, 6, 2, 1, 1, 0);
    send_frame(1, 2, 3, 0, 1, 0);
    send_frame(0, 6, 4, 0, 1, 0);
    send_frame(1, 8, 5, 0, 0, 5);
    send_frame(1, 6, 6, 2, 0, 13);
    send_item(OpFlush, 0, 0);
    write_cfg(CfgSsidOffset, 16'd0);
    send_frame(1, 5, 7, 0, 2, 0);
    write_cfg(CfgSsidOffset, 16'd2047);
    send_frame(1, 4, 8, 0, 1, 20);
    send_item(OpFlush, 0, 0);
    write_cfg(CfgReportInterval, 16'd1);
    write_cfg(CfgSsidOffset, 16'd12);
    send_item(OpTick, 0, 0);
    random_frame();

    for (int ph = 0; ph < 6; ph++) begin
      gap_mode = ph % 3;
      case (ph)
        0: write_cfg(CfgReportInterval, 16'd65535);
        1: write_cfg(CfgReportInterval, 16'($urandom_range(2, 8)));
        2: write_cfg(CfgSsidOffset, 16'($urandom_range(5, 24)));
        3: write_cfg(CfgReportInterval, 16'd1);
        4: write_cfg(CfgSsidOffset, 16'($urandom_range(0, 3)));
        default: write_cfg(CfgReportInterval, 16'd10);
      endcase
      for (int it = 0; it < 2; it++) begin
        r = $urandom_range(0, 99);
        if (r < 55) random_frame();
        else if (r < 63) send_frame(0, $urandom_range(4, 12), $urandom_range(0, 19), 0, 2, 0);
        else if (r < 70) send_frame(1, $urandom_range(0, 12), $urandom_range(0, 19),
                                    $urandom_range(0, 2), 0, $urandom_range(1, 20));
        else if (r < 84) repeat ($urandom_range(1, 5)) send_item(OpTick, $urandom_range(0, 255), $urandom_range(0, 1));
        else if (r < 92) send_item(OpFlush, $urandom_range(0, 255), $urandom_range(0, 1));
        else if (r < 96) send_item(OpNone, $urandom_range(0, 255), $urandom_range(0, 1));
        else drain();
      end
    end

    gap_mode = 0;
    send_item(OpFlush, 0, 0);

    drain();
    repeat (100) @(posedge clk_i);
    if (sb.pending.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending.size());
      sb.errors++;
    end
    if (sb.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/bsct_pkg.sv
rtl/core/bsct_ram.sv
rtl/core/bsct_div.sv
rtl/core/beacon_ssid_count_table_top.sv
sim/beacon_ssid_count_table_top_tb.sv
